// ===== rtl/kmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard and mouse port controller package
// Shared types, bus field widths, port decodes and fixed codes.
// ----------------------------------------------------------------------------
package kmpc_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int IN_FIELDS_W  = 44;
  localparam int IN_TDATA_W   = 48;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_FIELDS_W = 11;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [IN_TUSER_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_TICK  = 3'd2,
    OP_SCAN  = 3'd3,
    OP_MOUSE = 3'd4
  } op_t;

  localparam logic [7:0] PORT_KEY   = 8'h60;
  localparam logic [7:0] PORT_B     = 8'h61;
  localparam logic [7:0] PORT_SYS   = 8'h62;
  localparam logic [7:0] PORT_STAT1 = 8'h64;
  localparam logic [7:0] PORT_STAT2 = 8'h65;
  localparam logic [7:0] PORT_MX    = 8'h78;
  localparam logic [7:0] PORT_MY    = 8'h7A;

  localparam logic [7:0] CODE_SELFTEST = 8'hAA;
  localparam logic [7:0] CODE_L_PRESS  = 8'h7E;
  localparam logic [7:0] CODE_R_PRESS  = 8'h7D;
  localparam logic [7:0] CODE_L_REL    = 8'hFE;
  localparam logic [7:0] CODE_R_REL    = 8'hFD;

  localparam logic [7:0] STAT1_FORCE = 8'h0D;
  localparam logic [7:0] STAT1_MASK  = 8'h7F;
  localparam logic [7:0] READ_IDLE   = 8'hFF;

  localparam int PB_GATE     = 0;
  localparam int PB_ENABLE   = 1;
  localparam int PB_NIB_SEL  = 2;
  localparam int PB_SELFTEST = 6;
  localparam int PB_STATUS   = 7;

  typedef struct packed {
    logic       speaker_on;
    logic       speaker_gate;
    logic       irq_request;
    logic [7:0] read_data;
  } result_t;

endpackage

// ===== rtl/keyboard_mouse_port_controller_top.sv =====
// ----------------------------------------------------------------------------
// Keyboard and mouse port controller
// Port decode, scan-code ring, key latch, port B, status bytes and mouse
// counters of a PC-class keyboard and mouse port.
// ----------------------------------------------------------------------------
// Every input transaction carries one operation in in_tuser: a port read, a
// port write, a poll tick, a scan-code push or a mouse report. Each one gives
// exactly one output transaction with the read byte, the interrupt request of
// a tick and the speaker bits of port B after that operation.
// An accepted transaction lands in an input register. From there one pass of
// decode and state update writes the result register, from which the
// receiver takes the result. One transaction per cycle is sustained while
// out_tready stays high, set by the combinational state update between the
// two registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_tready drops only while both are occupied and out_tready is low.
// Reset clears both valid flags and all control and status state. The ring
// entries are not reset; a pop only reaches entries that were pushed.
// The ring wraps on overflow without a fullness check.
// ----------------------------------------------------------------------------
module keyboard_mouse_port_controller_top #(
  parameter int RING_DEPTH = kmpc_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // port_address, write_data, scan_code, mouse_dx, mouse_dy, mouse_buttons,
  // speaker_output, nmi_pending
  input  logic [kmpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic [kmpc_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_data, irq_request, speaker_gate, speaker_on
  output logic [kmpc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kmpc_pkg::*;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

  logic                    in_valid_r;
  logic [IN_FIELDS_W-1:0]  in_data_r;
  logic [IN_TUSER_W-1:0]   in_user_r;
  logic                    out_valid_r;
  result_t                 out_data_r;
  logic                    advance;

  logic [7:0]              ring_r [RING_DEPTH];
  logic [RING_AW-1:0]      head_r, head_nxt;
  logic [RING_AW-1:0]      tail_r, tail_nxt;
  logic [RING_AW-1:0]      tail_one;
  logic [7:0]              latched_key_r, latched_key_nxt;
  logic [7:0]              waiting_key_r, waiting_key_nxt;
  logic                    irq_wanted_r, irq_wanted_nxt;
  logic [7:0]              port_b_r, port_b_nxt;
  logic [7:0]              status_one_r, status_one_nxt;
  logic [7:0]              status_two_r, status_two_nxt;
  logic [7:0]              mouse_x_r, mouse_x_nxt;
  logic [7:0]              mouse_y_r, mouse_y_nxt;
  logic [1:0]              last_buttons_r, last_buttons_nxt;
  result_t                 result_nxt;

  logic [1:0]              push_cnt;
  logic [7:0]              push_code0, push_code1;

  op_t                     op;
  logic [7:0]              port_address;
  logic [7:0]              write_data;
  logic [7:0]              scan_code;
  logic signed [7:0]       mouse_dx;
  logic signed [7:0]       mouse_dy;
  logic [1:0]              mouse_buttons;
  logic                    speaker_output;
  logic                    nmi_pending;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
    ring_next = (idx == RING_LAST) ? '0 : idx + 1'b1;
  endfunction

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign op             = op_t'(in_user_r);
  assign port_address   = in_data_r[7:0];
  assign write_data     = in_data_r[15:8];
  assign scan_code      = in_data_r[23:16];
  assign mouse_dx       = in_data_r[31:24];
  assign mouse_dy       = in_data_r[39:32];
  assign mouse_buttons  = in_data_r[41:40];
  assign speaker_output = in_data_r[42];
  assign nmi_pending    = in_data_r[43];

  assign tail_one = ring_next(tail_r);

  always_comb begin
    logic lp, rp, lr, rr;
    logic [7:0] key_after;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    latched_key_nxt  = latched_key_r;
    waiting_key_nxt  = waiting_key_r;
    irq_wanted_nxt   = irq_wanted_r;
    port_b_nxt       = port_b_r;
    status_one_nxt   = status_one_r;
    status_two_nxt   = status_two_r;
    mouse_x_nxt      = mouse_x_r;
    mouse_y_nxt      = mouse_y_r;
    last_buttons_nxt = last_buttons_r;
    push_cnt         = 2'd0;
    push_code0       = scan_code;
    push_code1       = CODE_R_REL;
    result_nxt.read_data   = READ_IDLE;
    result_nxt.irq_request = 1'b0;
    lp = mouse_buttons[0] && !last_buttons_r[0];
    rp = mouse_buttons[1] && !last_buttons_r[1];
    lr = !mouse_buttons[0] && last_buttons_r[0];
    rr = !mouse_buttons[1] && last_buttons_r[1];
    key_after = irq_wanted_r ? waiting_key_r : latched_key_r;

    unique case (op)
      OP_READ: begin
        unique case (port_address)
          PORT_KEY: begin
            if (port_b_r[PB_STATUS]) begin
              result_nxt.read_data = (status_one_r | STAT1_FORCE) & STAT1_MASK;
            end else begin
              result_nxt.read_data = latched_key_r;
              if (head_r == tail_r) begin
                irq_wanted_nxt = 1'b0;
              end else begin
                waiting_key_nxt = ring_r[head_r];
                head_nxt        = ring_next(head_r);
                irq_wanted_nxt  = 1'b1;
              end
            end
          end
          PORT_B: result_nxt.read_data = port_b_r;
          PORT_SYS: begin
            result_nxt.read_data = {1'b0, nmi_pending, speaker_output, 1'b0,
                                    port_b_r[PB_NIB_SEL] ? status_two_r[3:0]
                                                         : status_two_r[7:4]};
          end
          PORT_MX: result_nxt.read_data = mouse_x_r;
          PORT_MY: result_nxt.read_data = mouse_y_r;
          default: result_nxt.read_data = READ_IDLE;
        endcase
      end
      OP_WRITE: begin
        unique case (port_address)
          PORT_B: begin
            if (!port_b_r[PB_SELFTEST] && write_data[PB_SELFTEST]) begin
              push_cnt   = 2'd1;
              push_code0 = CODE_SELFTEST;
            end
            port_b_nxt = write_data;
            if (write_data[PB_STATUS]) begin
              latched_key_nxt = 8'd0;
            end
          end
          PORT_STAT1: status_one_nxt = write_data;
          PORT_STAT2: status_two_nxt = write_data;
          PORT_MX:    mouse_x_nxt    = 8'd0;
          PORT_MY:    mouse_y_nxt    = 8'd0;
          default:    port_b_nxt     = port_b_r;
        endcase
      end
      OP_TICK: begin
        if (irq_wanted_r) begin
          irq_wanted_nxt         = 1'b0;
          latched_key_nxt        = waiting_key_r;
          result_nxt.irq_request = 1'b1;
        end
        if (head_r != tail_r && key_after == 8'd0) begin
          waiting_key_nxt = ring_r[head_r];
          head_nxt        = ring_next(head_r);
          irq_wanted_nxt  = 1'b1;
        end
      end
      OP_SCAN: begin
        push_cnt   = 2'd1;
        push_code0 = scan_code;
      end
      OP_MOUSE: begin
        mouse_x_nxt      = mouse_x_r + mouse_dx;
        mouse_y_nxt      = mouse_y_r - mouse_dy;
        last_buttons_nxt = mouse_buttons;
        // Left and right edges are independent, so at most two codes go in.
        push_cnt   = 2'({1'b0, lp} + {1'b0, rp} + {1'b0, lr} + {1'b0, rr});
        push_code0 = lp ? CODE_L_PRESS : rp ? CODE_R_PRESS :
                     lr ? CODE_L_REL   : CODE_R_REL;
        push_code1 = (lp && rp) ? CODE_R_PRESS : (rp && lr) ? CODE_L_REL
                                                            : CODE_R_REL;
      end
      default: begin
        result_nxt.read_data = READ_IDLE;
      end
    endcase

    if (push_cnt == 2'd1) begin
      tail_nxt = tail_one;
    end else if (push_cnt == 2'd2) begin
      tail_nxt = ring_next(tail_one);
    end

    result_nxt.speaker_gate = port_b_nxt[PB_GATE];
    result_nxt.speaker_on   = port_b_nxt[PB_ENABLE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      head_r         <= '0;
      tail_r         <= '0;
      latched_key_r  <= 8'd0;
      waiting_key_r  <= 8'd0;
      irq_wanted_r   <= 1'b0;
      port_b_r       <= 8'd0;
      status_one_r   <= 8'd0;
      status_two_r   <= 8'd0;
      mouse_x_r      <= 8'd0;
      mouse_y_r      <= 8'd0;
      last_buttons_r <= 2'd0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        head_r         <= head_nxt;
        tail_r         <= tail_nxt;
        latched_key_r  <= latched_key_nxt;
        waiting_key_r  <= waiting_key_nxt;
        irq_wanted_r   <= irq_wanted_nxt;
        port_b_r       <= port_b_nxt;
        status_one_r   <= status_one_nxt;
        status_two_r   <= status_two_nxt;
        mouse_x_r      <= mouse_x_nxt;
        mouse_y_r      <= mouse_y_nxt;
        last_buttons_r <= last_buttons_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[IN_FIELDS_W-1:0];
      in_user_r <= in_tuser;
    end
    if (advance) begin
      out_data_r <= result_nxt;
      if (push_cnt != 2'd0) begin
        ring_r[tail_r] <= push_code0;
      end
      if (push_cnt == 2'd2) begin
        ring_r[tail_one] <= push_code1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_data_r};

  a_irq_only_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result_nxt.irq_request) |-> (op == OP_TICK))
    else $error("keyboard interrupt raised by an operation other than a tick");

  a_pop_sets_irq : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && head_nxt != head_r) |=> irq_wanted_r)
    else $error("ring pop did not leave the interrupt pending");

  a_speaker_bits : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.speaker_gate == port_b_r[PB_GATE] &&
                     out_data_r.speaker_on == port_b_r[PB_ENABLE]))
    else $error("result speaker bits differ from port B");

endmodule
